// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define LBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define LBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lbs_pkg.sv
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 7;

  typedef enum logic [4:0] {
    S_LOAD,
    S_RI_RD, S_RI_LD, S_RK_RD, S_RK_CMP, S_RI_WR,
    S_FI_RD, S_FI_LD, S_FK_RD, S_FK_CMP, S_FI_WR,
    S_PK_RD, S_PK_LD, S_B1_RD, S_B1_WR, S_B2_RD, S_B2_WR,
    S_O_RD1, S_O_RD2, S_O_CAP, S_O_SHOW
  } lbs_state_t;

  typedef struct packed {
    logic elem_we;
    logic rise_we;
    logic fall_we;
    logic ord_we;
  } lbs_wr_t;

endpackage

// File: hdl/lbs_in_if.sv
`timescale 1ns / 1ps
interface lbs_in_if import lbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

// File: hdl/lbs_out_if.sv
`timescale 1ns / 1ps
interface lbs_out_if import lbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] out_value;
  logic [TOTAL_W-1:0] total_length;
  logic               run_end;

  modport source (output valid, output out_value, output total_length, output run_end,
                  input ready);
  modport sink (input valid, input out_value, input total_length, input run_end,
                output ready);
endinterface

// File: hdl/lbs_tables.sv
`timescale 1ns / 1ps
module lbs_tables import lbs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic               clk,
  input  lbs_wr_t            wr,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] elem_d,
  input  logic [CW-1:0]      len_d,
  input  logic [AW-1:0]      link_d,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] elem_q,
  output logic [CW-1:0]      rise_len_q,
  output logic [AW-1:0]      rise_link_q,
  output logic [CW-1:0]      fall_len_q,
  output logic [AW-1:0]      fall_link_q,
  output logic [AW-1:0]      ord_q
);

  logic [VALUE_W-1:0] elem_mem  [DEPTH];
  logic [CW-1:0]      rlen_mem  [DEPTH];
  logic [AW-1:0]      rlink_mem [DEPTH];
  logic [CW-1:0]      flen_mem  [DEPTH];
  logic [AW-1:0]      flink_mem [DEPTH];
  logic [AW-1:0]      ord_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.elem_we) begin
      elem_mem[wr_addr] <= elem_d;
    end
    if (wr.rise_we) begin
      rlen_mem[wr_addr]  <= len_d;
      rlink_mem[wr_addr] <= link_d;
    end
    if (wr.fall_we) begin
      flen_mem[wr_addr]  <= len_d;
      flink_mem[wr_addr] <= link_d;
    end
    if (wr.ord_we) begin
      ord_mem[wr_addr] <= link_d;
    end
    elem_q      <= elem_mem[rd_addr];
    rise_len_q  <= rlen_mem[rd_addr];
    rise_link_q <= rlink_mem[rd_addr];
    fall_len_q  <= flen_mem[rd_addr];
    fall_link_q <= flink_mem[rd_addr];
    ord_q       <= ord_mem[rd_addr];
  end

endmodule

// File: hdl/longest_bitonic_subsequence_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload                              Handshake
// in_ch    input      value, is_last                       valid / ready
// out_ch   output     out_value, total_length, run_end     valid / ready
//
// Loading takes one cycle per item; the block stays ready until an item marked last.
// The search then runs each compare as a read state and a compare state, set by the
// single read port shared by all tables.
// Building the output order reads and writes each result position in turn, and each
// result item is read, captured and shown; no input item is taken meanwhile.
// Reset is synchronous and active low; it clears the sequencer and the item count.
// A stalled result holds in its output register until it is taken.
module longest_bitonic_subsequence_unit import lbs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch
);

  `include "assert_macros.svh"

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  lbs_state_t state_r, state_nxt;

  logic [CW-1:0]      cnt_r, cur_len_r, rise_i_r, best_r, pos_r, plen_r;
  logic [AW-1:0]      i_r, k_r, cur_link_r, peak_r, idx_r;
  logic [VALUE_W-1:0] ei_r, out_val_r;

  lbs_wr_t            wr;
  logic [AW-1:0]      wr_addr, rd_addr, link_d;
  logic [CW-1:0]      len_d;
  logic [VALUE_W-1:0] elem_q;
  logic [CW-1:0]      rise_len_q, fall_len_q;
  logic [AW-1:0]      rise_link_q, fall_link_q, ord_q;

  logic          in_acc, out_acc, better, last_i_rise, last_k_rise, last_k_fall, last_out;
  logic [CW:0]   comb_len;

  lbs_tables #(.DEPTH(MAX_ITEMS), .AW(AW), .CW(CW)) u_tables (
    .clk         (clk),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .elem_d      (in_ch.value),
    .len_d       (len_d),
    .link_d      (link_d),
    .rd_addr     (rd_addr),
    .elem_q      (elem_q),
    .rise_len_q  (rise_len_q),
    .rise_link_q (rise_link_q),
    .fall_len_q  (fall_len_q),
    .fall_link_q (fall_link_q),
    .ord_q       (ord_q)
  );

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign better      = ($signed(elem_q) < $signed(ei_r)) &&
                       ((state_r == S_RK_CMP) ? (rise_len_q >= cur_len_r)
                                              : (fall_len_q >= cur_len_r));
  assign last_i_rise = (CW'(i_r) + ONE_C) == cnt_r;
  assign last_k_rise = (CW'(k_r) + ONE_C) == CW'(i_r);
  assign last_k_fall = CW'(k_r) == (CW'(i_r) + ONE_C);
  assign last_out    = (CW'(k_r) + ONE_C) == best_r;
  assign comb_len    = {1'b0, rise_i_r} + {1'b0, cur_len_r} - {1'b0, ONE_C};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_acc && in_ch.is_last) state_nxt = S_RI_RD;
      S_RI_RD:  state_nxt = S_RI_LD;
      S_RI_LD:  state_nxt = (i_r == '0) ? S_RI_WR : S_RK_RD;
      S_RK_RD:  state_nxt = S_RK_CMP;
      S_RK_CMP: state_nxt = last_k_rise ? S_RI_WR : S_RK_RD;
      S_RI_WR:  state_nxt = last_i_rise ? S_FI_RD : S_RI_RD;
      S_FI_RD:  state_nxt = S_FI_LD;
      S_FI_LD:  state_nxt = last_i_rise ? S_FI_WR : S_FK_RD;
      S_FK_RD:  state_nxt = S_FK_CMP;
      S_FK_CMP: state_nxt = last_k_fall ? S_FI_WR : S_FK_RD;
      S_FI_WR:  state_nxt = (i_r == '0) ? S_PK_RD : S_FI_RD;
      S_PK_RD:  state_nxt = S_PK_LD;
      S_PK_LD:  state_nxt = S_B1_RD;
      S_B1_RD:  state_nxt = S_B1_WR;
      S_B1_WR: begin
        if (pos_r != ONE_C) begin
          state_nxt = S_B1_RD;
        end else if (plen_r < best_r) begin
          state_nxt = S_B2_RD;
        end else begin
          state_nxt = S_O_RD1;
        end
      end
      S_B2_RD:  state_nxt = S_B2_WR;
      S_B2_WR:  state_nxt = ((pos_r + ONE_C) == best_r) ? S_O_RD1 : S_B2_RD;
      S_O_RD1:  state_nxt = S_O_RD2;
      S_O_RD2:  state_nxt = S_O_CAP;
      S_O_CAP:  state_nxt = S_O_SHOW;
      S_O_SHOW: if (out_acc) state_nxt = last_out ? S_LOAD : S_O_RD1;
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    wr      = '0;
    wr_addr = i_r;
    rd_addr = i_r;
    len_d   = cur_len_r;
    link_d  = cur_link_r;
    unique case (state_r)
      S_LOAD: begin
        wr.elem_we = in_acc && (cnt_r < MAX_C);
        wr_addr    = cnt_r[AW-1:0];
      end
      S_RK_RD, S_FK_RD: rd_addr = k_r;
      S_RI_WR:          wr.rise_we = 1'b1;
      S_FI_WR:          wr.fall_we = 1'b1;
      S_PK_RD:          rd_addr = peak_r;
      S_B1_RD, S_B2_RD: rd_addr = idx_r;
      S_B1_WR: begin
        wr.ord_we = 1'b1;
        wr_addr   = AW'(pos_r - ONE_C);
        link_d    = idx_r;
      end
      S_B2_WR: begin
        wr.ord_we = 1'b1;
        wr_addr   = AW'(pos_r);
        link_d    = fall_link_q;
      end
      S_O_RD1:  rd_addr = k_r;
      S_O_RD2:  rd_addr = ord_q;
      default: begin
      end
    endcase
  end

  assign in_ch.ready         = (state_r == S_LOAD);
  assign out_ch.valid        = (state_r == S_O_SHOW);
  assign out_ch.out_value    = out_val_r;
  assign out_ch.total_length = TOTAL_W'(best_r);
  assign out_ch.run_end      = last_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD && in_acc && cnt_r < MAX_C) begin
        cnt_r <= cnt_r + ONE_C;
      end
      if (state_r == S_O_SHOW && out_acc && last_out) begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: i_r <= '0;
      S_RI_LD, S_FI_LD: begin
        ei_r       <= elem_q;
        rise_i_r   <= rise_len_q;
        cur_len_r  <= ONE_C;
        cur_link_r <= i_r;
        k_r        <= (state_r == S_RI_LD) ? '0 : AW'(cnt_r - ONE_C);
      end
      S_RK_CMP, S_FK_CMP: begin
        if (better) begin
          cur_len_r  <= ((state_r == S_RK_CMP) ? rise_len_q : fall_len_q) + ONE_C;
          cur_link_r <= k_r;
        end
        k_r <= (state_r == S_RK_CMP) ? k_r + AW'(1) : k_r - AW'(1);
      end
      S_RI_WR: begin
        if (last_i_rise) begin
          best_r <= '0;
          peak_r <= '0;
        end else begin
          i_r <= i_r + AW'(1);
        end
      end
      S_FI_WR: begin
        if (comb_len > {1'b0, best_r}) begin
          best_r <= comb_len[CW-1:0];
          peak_r <= i_r;
        end
        i_r <= i_r - AW'(1);
      end
      S_PK_LD: begin
        pos_r  <= rise_len_q;
        plen_r <= rise_len_q;
        idx_r  <= peak_r;
      end
      S_B1_WR: begin
        pos_r <= pos_r - ONE_C;
        idx_r <= rise_link_q;
        k_r   <= '0;
        if (pos_r == ONE_C) begin
          pos_r <= plen_r;
          idx_r <= peak_r;
        end
      end
      S_B2_WR: begin
        pos_r <= pos_r + ONE_C;
        idx_r <= fall_link_q;
      end
      S_O_CAP:  out_val_r <= elem_q;
      S_O_SHOW: if (out_acc) k_r <= k_r + AW'(1);
      default: begin
      end
    endcase
  end

  `LBS_ASSERT(a_cnt_bound, cnt_r <= MAX_C, "item count beyond capacity")
  `LBS_ASSERT(a_no_overlap, !(in_ch.ready && out_ch.valid), "loading while a result is shown")
  `LBS_ASSERT(a_len_nonzero, out_ch.valid |-> (best_r != '0), "result with zero length")
  `LBS_ASSERT(a_end_reload, out_acc && out_ch.run_end |=> in_ch.ready && (cnt_r == '0), "set not cleared")

endmodule
